>>> hw/rtl/pdc_pkg.sv
// shared types, constants and helpers for the playfair digram cipher
// no dependencies; used by every module under hw/rtl but pdc_ram
package pdc_pkg;

  localparam int NUM_CELLS = 25;
  localparam int SIDE      = 5;
  localparam int POS_W     = 5;

  localparam logic [POS_W-1:0] FILL_FULL = 5'd25;

  localparam logic [7:0] CHAR_A = 8'h41;
  localparam logic [7:0] CHAR_J = 8'h4a;
  localparam logic [7:0] CHAR_Z = 8'h5a;

  typedef enum logic [1:0] {
    FUNC_CLEAR   = 2'd0,
    FUNC_KEY     = 2'd1,
    FUNC_FINISH  = 2'd2,
    FUNC_ENCRYPT = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_NOT_FOUND  = 2'd1,
    STATUS_INCOMPLETE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FINISH,
    ST_CALC,
    ST_READ,
    ST_RESULT
  } state_t;

  typedef struct packed {
    func_t      func;
    logic [7:0] letter_a;
    logic [7:0] letter_b;
  } item_t;

  typedef struct packed {
    logic [7:0] cipher_a;
    logic [7:0] cipher_b;
    status_t    status;
  } result_t;

  typedef struct packed {
    logic [NUM_CELLS-1:0] a;
    logic [NUM_CELLS-1:0] b;
  } lane_hits_t;

  typedef struct packed {
    logic             found_a;
    logic             found_b;
    logic [POS_W-1:0] pos_a;
    logic [POS_W-1:0] pos_b;
  } match_t;

  typedef struct packed {
    logic [2:0] row;
    logic [2:0] col;
  } rc_t;

  // square position (0..24) to row and column
  function automatic rc_t pos_to_rc(input logic [POS_W-1:0] pos);
    rc_t             rc;
    logic [POS_W-1:0] base;
    if (pos >= 5'd20) begin
      rc.row = 3'd4;
    end else if (pos >= 5'd15) begin
      rc.row = 3'd3;
    end else if (pos >= 5'd10) begin
      rc.row = 3'd2;
    end else if (pos >= 5'd5) begin
      rc.row = 3'd1;
    end else begin
      rc.row = 3'd0;
    end
    base   = {rc.row[2:0], 2'b00} + {2'b00, rc.row};
    rc.col = 3'(pos - base);
    return rc;
  endfunction

  // row and column back to a square position
  function automatic logic [POS_W-1:0] rc_to_pos(input logic [2:0] row,
                                                 input logic [2:0] col);
    return {row, 2'b00} + {2'b00, row} + {2'b00, col};
  endfunction

  // step one place along a side of the square with wrap
  function automatic logic [2:0] wrap_inc(input logic [2:0] v);
    return (v == 3'(SIDE - 1)) ? 3'd0 : v + 3'd1;
  endfunction

endpackage

>>> hw/rtl/pdc_ram.sv
// generic single write port, dual registered read port ram
// no dependencies
module pdc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 25
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

>>> hw/rtl/pdc_lane.sv
// one square cell: holds its letter and compares it against both probes
// depends on pdc_pkg
module pdc_lane #(
  parameter int LANE_IDX = 0
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [pdc_pkg::POS_W-1:0]  wr_idx,
  input  logic [7:0]                 wr_data,
  input  logic [pdc_pkg::POS_W-1:0]  fill,
  input  logic [7:0]                 probe_a,
  input  logic [7:0]                 probe_b,
  output logic                       hit_a,
  output logic                       hit_b
);

  localparam logic [pdc_pkg::POS_W-1:0] IDX = pdc_pkg::POS_W'(LANE_IDX);

  logic [7:0] entry;
  logic       held;

  always_ff @(posedge clk) begin
    if (wr_en && wr_idx == IDX) begin
      entry <= wr_data;
    end
  end

  // cells at or beyond the fill count are not part of the square
  assign held  = IDX < fill;
  assign hit_a = held && (entry == probe_a);
  assign hit_b = held && (entry == probe_b);

endmodule

>>> hw/rtl/pdc_merge.sv
// merges the lane hits: lowest matching cell wins for each probe
// depends on pdc_pkg
module pdc_merge (
  input  pdc_pkg::lane_hits_t hits,
  output pdc_pkg::match_t     match
);

  always_comb begin
    match = '0;
    for (int k = pdc_pkg::NUM_CELLS - 1; k >= 0; k--) begin
      if (hits.a[k]) begin
        match.found_a = 1'b1;
        match.pos_a   = pdc_pkg::POS_W'(k);
      end
      if (hits.b[k]) begin
        match.found_b = 1'b1;
        match.pos_b   = pdc_pkg::POS_W'(k);
      end
    end
  end

endmodule

>>> hw/rtl/playfair_digram_cipher.sv
// playfair digram cipher top level: control, 25 compare lanes, merge, square ram
// depends on pdc_pkg, pdc_lane, pdc_merge, pdc_ram
//
//   channel  | valid        | stall        | payload
//   ---------+--------------+--------------+------------------------
//   input    | item_valid   | item_stall   | item   (pdc_pkg::item_t)
//   output   | result_valid | result_stall | result (pdc_pkg::result_t)
//
// clear and key letter go straight to output load; encrypt runs lane compare,
// corner math, square ram read and output load, or skips to output load on an
// incomplete square and skips the read when a letter is missing; finish feeds one
// alphabet letter per cycle through the lane compare, until Z or a full square.
// rst is synchronous active high and empties the square (fill count only).
// an item is taken only in idle; a finished result waits in its own register
// while result_stall is high, and the next item may be accepted meanwhile.
module playfair_digram_cipher (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  pdc_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_stall,
  output pdc_pkg::result_t result
);

  pdc_pkg::state_t   state, state_next;
  logic [pdc_pkg::POS_W-1:0] fill, fill_next;
  logic [7:0]        cand, cand_next;
  pdc_pkg::match_t   match_reg, match_reg_next;
  pdc_pkg::result_t  res, res_next;

  pdc_pkg::lane_hits_t hits;
  pdc_pkg::match_t     match;
  logic [7:0]          probe_a;
  logic                append_en;
  logic                finish_done;
  logic                load_out;
  logic [7:0]          rdata_a, rdata_b;
  logic [pdc_pkg::POS_W-1:0] raddr_a, raddr_b;
  pdc_pkg::rc_t        rc_a, rc_b;
  logic                not_full;

  assign not_full = fill < pdc_pkg::FILL_FULL;

  // compare lanes
  for (genvar g = 0; g < pdc_pkg::NUM_CELLS; g++) begin : g_lane
    pdc_lane #(.LANE_IDX(g)) u_lane (
      .clk     (clk),
      .wr_en   (append_en),
      .wr_idx  (fill),
      .wr_data (probe_a),
      .fill    (fill),
      .probe_a (probe_a),
      .probe_b (item.letter_b),
      .hit_a   (hits.a[g]),
      .hit_b   (hits.b[g])
    );
  end

  pdc_merge u_merge (
    .hits  (hits),
    .match (match)
  );

  pdc_ram #(.WIDTH(8), .DEPTH(pdc_pkg::NUM_CELLS)) u_ram (
    .clk     (clk),
    .we      (append_en),
    .waddr   (fill),
    .wdata   (probe_a),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  assign finish_done = (cand == pdc_pkg::CHAR_Z) || !not_full;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      pdc_pkg::ST_IDLE: begin
        if (item_valid) begin
          unique case (item.func)
            pdc_pkg::FUNC_CLEAR, pdc_pkg::FUNC_KEY: state_next = pdc_pkg::ST_RESULT;
            pdc_pkg::FUNC_FINISH:  state_next = pdc_pkg::ST_FINISH;
            pdc_pkg::FUNC_ENCRYPT: state_next = not_full ? pdc_pkg::ST_RESULT
                                                         : pdc_pkg::ST_CALC;
            default:               state_next = pdc_pkg::ST_RESULT;
          endcase
        end
      end
      pdc_pkg::ST_FINISH: begin
        if (finish_done) state_next = pdc_pkg::ST_RESULT;
      end
      pdc_pkg::ST_CALC: begin
        state_next = (match_reg.found_a && match_reg.found_b) ? pdc_pkg::ST_READ
                                                              : pdc_pkg::ST_RESULT;
      end
      pdc_pkg::ST_READ:   state_next = pdc_pkg::ST_RESULT;
      pdc_pkg::ST_RESULT: begin
        if (load_out) state_next = pdc_pkg::ST_IDLE;
      end
      default: state_next = pdc_pkg::ST_IDLE;
    endcase
  end

  // outputs of the state machine
  always_comb begin
    item_stall     = 1'b1;
    probe_a        = item.letter_a;
    append_en      = 1'b0;
    fill_next      = fill;
    cand_next      = cand;
    match_reg_next = match_reg;
    res_next       = res;
    load_out       = 1'b0;
    rc_a           = pdc_pkg::pos_to_rc(match_reg.pos_a);
    rc_b           = pdc_pkg::pos_to_rc(match_reg.pos_b);
    raddr_a        = '0;
    raddr_b        = '0;
    unique case (state)
      pdc_pkg::ST_IDLE: begin
        item_stall = 1'b0;
        res_next   = '0;
        if (item_valid) begin
          unique case (item.func)
            pdc_pkg::FUNC_CLEAR: fill_next = '0;
            pdc_pkg::FUNC_KEY: begin
              append_en = !match.found_a && not_full;
            end
            pdc_pkg::FUNC_FINISH: cand_next = pdc_pkg::CHAR_A;
            pdc_pkg::FUNC_ENCRYPT: begin
              match_reg_next = match;
              if (not_full) res_next.status = pdc_pkg::STATUS_INCOMPLETE;
            end
            default: fill_next = fill;
          endcase
        end
      end
      pdc_pkg::ST_FINISH: begin
        probe_a   = cand;
        append_en = !match.found_a && not_full;
        // the alphabet walk skips J
        cand_next = (cand + 8'd1 == pdc_pkg::CHAR_J) ? cand + 8'd2 : cand + 8'd1;
      end
      pdc_pkg::ST_CALC: begin
        if (!(match_reg.found_a && match_reg.found_b)) begin
          res_next.status = pdc_pkg::STATUS_NOT_FOUND;
        end else if (rc_a.row == rc_b.row) begin
          raddr_a = pdc_pkg::rc_to_pos(rc_a.row, pdc_pkg::wrap_inc(rc_a.col));
          raddr_b = pdc_pkg::rc_to_pos(rc_b.row, pdc_pkg::wrap_inc(rc_b.col));
        end else if (rc_a.col == rc_b.col) begin
          raddr_a = pdc_pkg::rc_to_pos(pdc_pkg::wrap_inc(rc_a.row), rc_a.col);
          raddr_b = pdc_pkg::rc_to_pos(pdc_pkg::wrap_inc(rc_b.row), rc_b.col);
        end else begin
          // rectangle corners swap columns
          raddr_a = pdc_pkg::rc_to_pos(rc_a.row, rc_b.col);
          raddr_b = pdc_pkg::rc_to_pos(rc_b.row, rc_a.col);
        end
      end
      pdc_pkg::ST_READ: begin
        res_next.cipher_a = rdata_a;
        res_next.cipher_b = rdata_b;
        res_next.status   = pdc_pkg::STATUS_OK;
      end
      pdc_pkg::ST_RESULT: begin
        load_out = !result_valid || !result_stall;
      end
      default: item_stall = 1'b1;
    endcase
    if (append_en) fill_next = fill + 5'd1;
    // no transaction is taken while in reset
    if (rst) item_stall = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= pdc_pkg::ST_IDLE;
      fill         <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
      if (load_out) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cand      <= cand_next;
    match_reg <= match_reg_next;
    res       <= res_next;
    if (load_out) begin
      result <= res;
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= pdc_pkg::FILL_FULL)
    else $error("fill count beyond square size");

  a_fill_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == pdc_pkg::ST_CALC || state == pdc_pkg::ST_READ ||
     state == pdc_pkg::ST_RESULT) |=> $stable(fill))
    else $error("square changed while an encrypt or result was pending");

  a_result_load: assert property (@(posedge clk) disable iff (rst)
    (state == pdc_pkg::ST_RESULT && (!result_valid || !result_stall))
      |=> (result_valid && state == pdc_pkg::ST_IDLE))
    else $error("finished transaction not moved to the output register");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.status != pdc_pkg::STATUS_OK)
      |-> (result.cipher_a == 8'd0 && result.cipher_b == 8'd0))
    else $error("error status with nonzero cipher letters");
`endif

endmodule

>>> sim/playfair_digram_cipher_checker.sv
// predicts and checks playfair digram cipher results seen on both channels
// depends on pdc_pkg; instantiated beside the block by playfair_digram_cipher_tb
module playfair_digram_cipher_checker (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  input  logic             item_stall,
  input  pdc_pkg::item_t   item,
  input  logic             result_valid,
  input  logic             result_stall,
  input  pdc_pkg::result_t result,
  output int               errors,
  output int               pending
);

  logic [7:0]       key_square [pdc_pkg::NUM_CELLS];
  int               key_fill;
  pdc_pkg::result_t pending_ciphers [$];
  pdc_pkg::result_t predicted;
  pdc_pkg::result_t oldest;

  initial begin
    errors  = 0;
    pending = 0;
  end

  task automatic report(input string msg);
    $display("cipher check mismatch at %0t: %s", $time, msg);
    errors++;
  endtask

  // first held entry wins, only filled entries are searched
  function automatic int locate(input logic [7:0] c);
    for (int k = 0; k < key_fill; k++) begin
      if (key_square[k] == c) return k;
    end
    return -1;
  endfunction

  task automatic append_letter(input logic [7:0] c);
    if (key_fill < pdc_pkg::NUM_CELLS && locate(c) < 0) begin
      key_square[key_fill] = c;
      key_fill++;
    end
  endtask

  task automatic cipher_step(input pdc_pkg::item_t it, output pdc_pkg::result_t r);
    int         pa, pb, r1, c1, r2, c2, o1, o2;
    logic [7:0] ch;
    r          = '0;
    r.status   = pdc_pkg::STATUS_OK;
    case (it.func)
      pdc_pkg::FUNC_CLEAR: begin
        key_fill = 0;
      end
      pdc_pkg::FUNC_KEY: begin
        append_letter(it.letter_a);
      end
      pdc_pkg::FUNC_FINISH: begin
        for (ch = pdc_pkg::CHAR_A; ch <= pdc_pkg::CHAR_Z; ch++) begin
          if (ch != pdc_pkg::CHAR_J) append_letter(ch);
        end
      end
      pdc_pkg::FUNC_ENCRYPT: begin
        if (key_fill < pdc_pkg::NUM_CELLS) begin
          r.status = pdc_pkg::STATUS_INCOMPLETE;
        end else begin
          pa = locate(it.letter_a);
          pb = locate(it.letter_b);
          if (pa < 0 || pb < 0) begin
            r.status = pdc_pkg::STATUS_NOT_FOUND;
          end else begin
            r1 = pa / pdc_pkg::SIDE;
            c1 = pa % pdc_pkg::SIDE;
            r2 = pb / pdc_pkg::SIDE;
            c2 = pb % pdc_pkg::SIDE;
            // identical letters share a row, so they take the right neighbor
            if (r1 == r2) begin
              o1 = r1 * pdc_pkg::SIDE + (c1 + 1) % pdc_pkg::SIDE;
              o2 = r2 * pdc_pkg::SIDE + (c2 + 1) % pdc_pkg::SIDE;
            end else if (c1 == c2) begin
              o1 = ((r1 + 1) % pdc_pkg::SIDE) * pdc_pkg::SIDE + c1;
              o2 = ((r2 + 1) % pdc_pkg::SIDE) * pdc_pkg::SIDE + c2;
            end else begin
              o1 = r1 * pdc_pkg::SIDE + c2;
              o2 = r2 * pdc_pkg::SIDE + c1;
            end
            r.cipher_a = key_square[o1];
            r.cipher_b = key_square[o2];
          end
        end
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      key_fill = 0;
      pending_ciphers.delete();
    end else begin
      if (result_valid && !result_stall) begin
        if (pending_ciphers.size() == 0) begin
          report($sformatf("result %h with no transaction outstanding", result));
        end else begin
          oldest = pending_ciphers.pop_front();
          if (result.cipher_a !== oldest.cipher_a)
            report($sformatf("cipher_a got %h want %h", result.cipher_a, oldest.cipher_a));
          if (result.cipher_b !== oldest.cipher_b)
            report($sformatf("cipher_b got %h want %h", result.cipher_b, oldest.cipher_b));
          if (result.status !== oldest.status)
            report($sformatf("status got %0d want %0d", result.status, oldest.status));
        end
      end
      if (item_valid && !item_stall) begin
        cipher_step(item, predicted);
        pending_ciphers.push_back(predicted);
      end
    end
    pending <= pending_ciphers.size();
  end

endmodule

>>> sim/playfair_digram_cipher_tb.sv
// stimulus, clock, reset and verdict for the playfair digram cipher
// depends on pdc_pkg, the block under hw/rtl and playfair_digram_cipher_checker
module playfair_digram_cipher_tb;

  localparam int RANDOM_ITEMS = 550;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int TAIL_CYCLES  = 40;
  localparam int ITEM_W       = $bits(pdc_pkg::item_t);

  logic             clk;
  logic             rst;
  logic             item_valid;
  logic             item_stall;
  pdc_pkg::item_t   item;
  logic             result_valid;
  logic             result_stall;
  pdc_pkg::result_t result;
  int               errors;
  int               pending;
  int               cycle_count = 0;
  int               random_sent = 0;
  bit               calm_input  = 1'b0;
  logic [7:0]       key_bytes [$];

  playfair_digram_cipher DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  playfair_digram_cipher_checker u_cipher_check (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .errors       (errors),
    .pending      (pending)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // mostly short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return pdc_pkg::CHAR_A + 8'($urandom_range(0, 25));
    if (r < 70) return 8'h61 + 8'($urandom_range(0, 25));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] pick_plain();
    int         r;
    logic [7:0] c;
    r = $urandom_range(0, 99);
    if (r < 45 && key_bytes.size() > 0)
      return key_bytes[$urandom_range(0, key_bytes.size() - 1)];
    if (r < 92) begin
      c = pdc_pkg::CHAR_A + 8'($urandom_range(0, 24));
      if (c >= pdc_pkg::CHAR_J) c++;
      return c;
    end
    if (r < 96) return pdc_pkg::CHAR_J;
    return 8'($urandom_range(0, 255));
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic send(input pdc_pkg::func_t f, input logic [7:0] a, input logic [7:0] b);
    pdc_pkg::item_t    next_item;
    logic [ITEM_W-1:0] junk;
    int                gap;
    next_item.func     = f;
    next_item.letter_a = a;
    next_item.letter_b = b;
    item       <= next_item;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
    @(negedge clk);
    gap = calm_input ? 0 : pick_gap();
    if (gap > 0) begin
      junk        = ITEM_W'($urandom);
      item_valid <= 1'b0;
      item       <= junk;
      repeat (gap) @(negedge clk);
    end
  endtask

  // random-part transaction, sometimes preceded by a fully random one
  task automatic emit(input pdc_pkg::func_t f, input logic [7:0] a, input logic [7:0] b);
    if ($urandom_range(0, 99) < 7) begin
      send(pdc_pkg::func_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
           8'($urandom_range(0, 255)));
      random_sent++;
    end
    send(f, a, b);
    random_sent++;
  endtask

  // receiver stalls, with occasional calm stretches
  initial begin
    int hold;
    int r;
    hold         = 0;
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        hold--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 5) begin
          result_stall <= 1'b0;
          hold = $urandom_range(50, 200);
        end else if (r < 60) begin
          result_stall <= 1'b0;
          hold = $urandom_range(0, 3);
        end else begin
          result_stall <= 1'b1;
          hold = pick_gap();
        end
      end
    end
  end

  initial begin
    int         nkeys;
    int         nenc;
    logic [7:0] a;
    logic [7:0] b;
    rst        = 1'b1;
    item_valid = 1'b0;
    item       = '0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send(pdc_pkg::FUNC_ENCRYPT, pdc_pkg::CHAR_A, pdc_pkg::CHAR_Z);   // empty square
    send(pdc_pkg::FUNC_KEY, 8'h00, 8'hff);
    send(pdc_pkg::FUNC_KEY, 8'hff, 8'h00);
    send(pdc_pkg::FUNC_KEY, pdc_pkg::CHAR_J, 8'h00);
    send(pdc_pkg::FUNC_KEY, "a", 8'hff);           // lowercase held as given
    send(pdc_pkg::FUNC_KEY, 8'hff, 8'h00);         // already held
    send(pdc_pkg::FUNC_ENCRYPT, 8'h00, 8'hff);     // square not complete
    send(pdc_pkg::FUNC_FINISH, 8'hff, 8'hff);
    send(pdc_pkg::FUNC_FINISH, 8'h00, 8'h00);      // already full
    send(pdc_pkg::FUNC_KEY, "W", 8'h00);           // full square ignores key
    send(pdc_pkg::FUNC_ENCRYPT, "a", pdc_pkg::CHAR_A);      // same row, wraps to row start
    send(pdc_pkg::FUNC_ENCRYPT, "V", "R");
    send(pdc_pkg::FUNC_ENCRYPT, 8'h00, "R");       // same column, wraps to top
    send(pdc_pkg::FUNC_ENCRYPT, "V", "F");
    send(pdc_pkg::FUNC_ENCRYPT, "C", "Q");         // rectangle
    send(pdc_pkg::FUNC_ENCRYPT, 8'hff, "V");
    send(pdc_pkg::FUNC_ENCRYPT, "E", "E");         // identical letters
    send(pdc_pkg::FUNC_ENCRYPT, "W", pdc_pkg::CHAR_A);      // first letter missing
    send(pdc_pkg::FUNC_ENCRYPT, pdc_pkg::CHAR_A, pdc_pkg::CHAR_Z);   // second letter missing
    send(pdc_pkg::FUNC_CLEAR, 8'hff, 8'hff);
    send(pdc_pkg::FUNC_ENCRYPT, pdc_pkg::CHAR_A, pdc_pkg::CHAR_A);
    send(pdc_pkg::FUNC_FINISH, 8'h00, 8'hff);
    send(pdc_pkg::FUNC_ENCRYPT, pdc_pkg::CHAR_Z, pdc_pkg::CHAR_A);

    while (random_sent < RANDOM_ITEMS) begin
      calm_input = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 9) != 0) begin
        emit(pdc_pkg::FUNC_CLEAR, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        key_bytes.delete();
      end
      nkeys = $urandom_range(0, 12);
      repeat (nkeys) begin
        a = pick_key();
        key_bytes.push_back(a);
        emit(pdc_pkg::FUNC_KEY, a, 8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 9) != 0)
        emit(pdc_pkg::FUNC_FINISH, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      nenc = $urandom_range(5, 30);
      repeat (nenc) begin
        a = pick_plain();
        b = ($urandom_range(0, 99) < 15) ? a : pick_plain();
        emit(pdc_pkg::FUNC_ENCRYPT, a, b);
      end
    end

    item_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> playfair_digram_cipher.f
hw/rtl/pdc_pkg.sv
hw/rtl/pdc_ram.sv
hw/rtl/pdc_lane.sv
hw/rtl/pdc_merge.sv
hw/rtl/playfair_digram_cipher.sv
sim/playfair_digram_cipher_checker.sv
sim/playfair_digram_cipher_tb.sv
